FILE: hw/rtl/slp_pkg.sv
`default_nettype none

package slp_pkg;

   // Fixed field widths of the block's ports and registers.
   localparam int SAMPLE_W   = 16;
   localparam int ADDR_IN_W  = 16;
   localparam int FUNC_W     = 2;
   localparam int STEP_W     = 24;
   localparam int STEP_FRAC  = 16;
   localparam int VOL_W      = 16;
   localparam int VOL_FRAC   = 14;
   localparam int LEN_W      = 16;
   localparam int BLK_W      = 13;

   // Register file geometry.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   // Depth of the queue between the front end and the execution unit.
   localparam int QUEUE_DEPTH = 2;

   // Register reset values.
   localparam logic [STEP_W-1:0] STEP_RESET = 24'd65536;
   localparam logic [VOL_W-1:0]  VOL_RESET  = 16'd16384;
   localparam logic [BLK_W-1:0]  BLK_RESET  = 13'd256;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_STEP    = 3'd0,
      REG_VOLUME  = 3'd1,
      REG_REVERSE = 3'd2,
      REG_BYPASS  = 3'd3,
      REG_LENGTH  = 3'd4,
      REG_BLOCK   = 3'd5
   } slp_reg_type;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_START = 2'd1,
      FUNC_FRAME = 2'd2
   } slp_func_type;

   typedef enum logic [1:0] {
      OP_NOP,
      OP_LOAD,
      OP_START,
      OP_FRAME
   } slp_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD1,
      ST_MULD,
      ST_SUM,
      ST_MULV,
      ST_ACC,
      ST_DONE
   } slp_state_type;

   typedef struct packed {
      slp_op_type                  op;
      logic [ADDR_IN_W-1:0]        addr;
      logic signed [SAMPLE_W-1:0]  left;
      logic signed [SAMPLE_W-1:0]  right;
   } slp_cmd_type;

   typedef struct packed {
      logic        valid;
      slp_cmd_type cmd;
   } slp_head_type;

   typedef struct packed {
      logic [STEP_W-1:0] step;
      logic [VOL_W-1:0]  volume;
      logic              reverse;
      logic              bypass;
      logic [LEN_W-1:0]  length;
      logic [BLK_W-1:0]  block_frames;
   } slp_cfg_type;

   typedef struct packed {
      logic cap_a;
      logic mul_d;
      logic sum;
      logic mul_v;
      logic acc;
   } slp_lane_ctl_type;

endpackage

`default_nettype wire

FILE: hw/rtl/stereo_linear_interp_sample_player.sv
`default_nettype none

// Channel  Direction  Handshake                     Payload
// req      in         push / full                   req_func, req_addr, req_left_in, req_right_in
// rsp      out        pop / empty                   rsp_left_out, rsp_right_out, rsp_playing
// csr      in / out   psel, penable, pwrite, pready step, volume, reverse, bypass, length,
//                                                   block_frames
//
// A transaction passes through the two-entry input queue before execution.
// Loads, starts, unknown codes and frames while stopped execute at once; a played
// frame steps through RD1, MULD, SUM, MULV, ACC and DONE, set by the two reads of
// the single-port sample store and the registered multiply stages; a bypass frame goes to DONE.
// Reset is synchronous: it clears the queue, playback state and result register and
// restores register defaults; the sample store is not cleared.
// A waiting result holds the last execution step, while the queue still accepts input.
module stereo_linear_interp_sample_player #(
   parameter int ADDR_BITS = 16,
   parameter int FRAC_BITS = 16,
   parameter int MAX_BLOCK = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic [slp_pkg::FUNC_W-1:0]           req_func,
   input  logic [slp_pkg::ADDR_IN_W-1:0]        req_addr,
   input  logic signed [slp_pkg::SAMPLE_W-1:0]  req_left_in,
   input  logic signed [slp_pkg::SAMPLE_W-1:0]  req_right_in,
   output logic                                 empty,
   input  logic                                 pop,
   output logic signed [slp_pkg::SAMPLE_W-1:0]  rsp_left_out,
   output logic signed [slp_pkg::SAMPLE_W-1:0]  rsp_right_out,
   output logic                                 rsp_playing,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [slp_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [slp_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [slp_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                 pready
);
   import slp_pkg::*;

   slp_cfg_type            cfg_ff, cfg_in;
   slp_head_type           head;
   logic                   take;
   logic                   csr_write;
   logic [REG_IDX_W-1:0]   reg_idx;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign reg_idx   = paddr[CSR_ADDR_W-1:2];

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (slp_reg_type'(reg_idx))
            REG_STEP:    cfg_in.step         = pwdata[STEP_W-1:0];
            REG_VOLUME:  cfg_in.volume       = pwdata[VOL_W-1:0];
            REG_REVERSE: cfg_in.reverse      = pwdata[0];
            REG_BYPASS:  cfg_in.bypass       = pwdata[0];
            REG_LENGTH:  cfg_in.length       = pwdata[LEN_W-1:0];
            REG_BLOCK:   cfg_in.block_frames = pwdata[BLK_W-1:0];
            default:     cfg_in              = cfg_ff;
         endcase
      end
   end

   // Register reads.
   always_comb begin
      case (slp_reg_type'(reg_idx))
         REG_STEP:    prdata = CSR_DATA_W'(cfg_ff.step);
         REG_VOLUME:  prdata = CSR_DATA_W'(cfg_ff.volume);
         REG_REVERSE: prdata = CSR_DATA_W'(cfg_ff.reverse);
         REG_BYPASS:  prdata = CSR_DATA_W'(cfg_ff.bypass);
         REG_LENGTH:  prdata = CSR_DATA_W'(cfg_ff.length);
         REG_BLOCK:   prdata = CSR_DATA_W'(cfg_ff.block_frames);
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step         <= STEP_RESET;
         cfg_ff.volume       <= VOL_RESET;
         cfg_ff.reverse      <= 1'b0;
         cfg_ff.bypass       <= 1'b0;
         cfg_ff.length       <= '0;
         cfg_ff.block_frames <= BLK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   slp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .func     (req_func),
      .addr     (req_addr),
      .left_in  (req_left_in),
      .right_in (req_right_in),
      .head     (head),
      .take     (take)
   );

   slp_back #(
      .ADDR_BITS (ADDR_BITS),
      .FRAC_BITS (FRAC_BITS),
      .MAX_BLOCK (MAX_BLOCK)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .take      (take),
      .cfg       (cfg_ff),
      .pop       (pop),
      .empty     (empty),
      .left_out  (rsp_left_out),
      .right_out (rsp_right_out),
      .playing   (rsp_playing)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/slp_front.sv
`default_nettype none

module slp_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [slp_pkg::FUNC_W-1:0]          func,
   input  logic [slp_pkg::ADDR_IN_W-1:0]       addr,
   input  logic signed [slp_pkg::SAMPLE_W-1:0] left_in,
   input  logic signed [slp_pkg::SAMPLE_W-1:0] right_in,
   output slp_pkg::slp_head_type               head,
   input  logic                                take
);
   import slp_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   slp_cmd_type      queue_ff [QUEUE_DEPTH];
   slp_cmd_type      cmd_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             wr_en;
   logic             rd_en;

   // Classify the incoming transaction into an operation code.
   always_comb begin
      cmd_in.addr  = addr;
      cmd_in.left  = left_in;
      cmd_in.right = right_in;
      case (slp_func_type'(func))
         FUNC_LOAD:  cmd_in.op = OP_LOAD;
         FUNC_START: cmd_in.op = OP_START;
         FUNC_FRAME: cmd_in.op = OP_FRAME;
         default:    cmd_in.op = OP_NOP;
      endcase
   end

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign wr_en      = push && !full;
   assign rd_en      = take && head.valid;
   assign head.valid = (count_ff != '0);
   assign head.cmd   = queue_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage; entries carry no reset.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         queue_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   // The execution unit only takes a transaction that is actually queued.
   assert property (@(posedge clock) disable iff (reset) take |-> (count_ff != '0))
      else $error("slp_front: take while the queue is empty");

endmodule

`default_nettype wire

FILE: hw/rtl/slp_lane.sv
`default_nettype none

module slp_lane #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  slp_pkg::slp_lane_ctl_type           ctl,
   input  logic signed [slp_pkg::SAMPLE_W-1:0] rd_sample,
   input  logic                                va,
   input  logic                                vb,
   input  logic [FRAC_BITS-1:0]                frac,
   input  logic [slp_pkg::VOL_W-1:0]           volume,
   output logic signed [slp_pkg::SAMPLE_W-1:0] sample_out
);
   import slp_pkg::*;

   localparam int DIFF_W = SAMPLE_W + 1;
   localparam int V_W    = FRAC_BITS + SAMPLE_W + 2;
   localparam int H      = V_W / 2;
   localparam int VH_W   = V_W - H;
   localparam int VOLS_W = VOL_W + 1;
   localparam int PPH_W  = VH_W + VOLS_W;
   localparam int PPL_W  = H + VOL_W;
   localparam int P_W    = V_W + VOLS_W;
   localparam int SH     = FRAC_BITS + VOL_FRAC;
   localparam int Q_W    = P_W - SH;

   logic signed [SAMPLE_W-1:0] a_ff, a_in;
   logic signed [SAMPLE_W-1:0] b;
   logic signed [DIFF_W-1:0]   d;
   logic signed [V_W-1:0]      prod_ff, prod_in;
   logic signed [V_W-1:0]      v_ff, v_in;
   logic signed [VH_W-1:0]     vh;
   logic [H-1:0]               vl;
   logic signed [VOLS_W-1:0]   vol_s;
   logic signed [PPH_W-1:0]    pph_ff, pph_in;
   logic [PPL_W-1:0]           ppl_ff, ppl_in;
   logic signed [P_W-1:0]      p_ff, p_in;
   logic signed [P_W-1:0]      p_bias;
   logic signed [Q_W-1:0]      q;

   // Interpolation and gain stages, each gated by the sequencer.
   always_comb begin
      b     = vb ? rd_sample : '0;
      d     = DIFF_W'(b) - DIFF_W'(a_ff);
      vh    = v_ff[V_W-1:H];
      vl    = v_ff[H-1:0];
      vol_s = $signed({1'b0, volume});

      a_in    = ctl.cap_a ? (va ? rd_sample : '0) : a_ff;
      prod_in = ctl.mul_d ? V_W'(d) * V_W'($signed({1'b0, frac})) : prod_ff;
      v_in    = ctl.sum ? (V_W'(a_ff) <<< FRAC_BITS) + prod_ff : v_ff;
      // The gain product is split into two partial products over the halves of v.
      pph_in  = ctl.mul_v ? PPH_W'(vh) * PPH_W'(vol_s) : pph_ff;
      ppl_in  = ctl.mul_v ? PPL_W'(vl) * PPL_W'(volume) : ppl_ff;
      p_in    = ctl.acc ? (P_W'(pph_ff) <<< H) + $signed(P_W'(ppl_ff)) : p_ff;
   end

   // Scale down with truncation toward zero, then saturate to the sample range.
   always_comb begin
      p_bias = p_ff[P_W-1] ? p_ff + $signed(P_W'({SH{1'b1}})) : p_ff;
      q      = Q_W'(p_bias >>> SH);
      if ((&q[Q_W-1:SAMPLE_W-1]) || !(|q[Q_W-1:SAMPLE_W-1])) begin
         sample_out = q[SAMPLE_W-1:0];
      end else if (q[Q_W-1]) begin
         sample_out = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         sample_out = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      prod_ff <= prod_in;
      v_ff    <= v_in;
      pph_ff  <= pph_in;
      ppl_ff  <= ppl_in;
      p_ff    <= p_in;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/slp_back.sv
`default_nettype none

module slp_back #(
   parameter int ADDR_BITS = 16,
   parameter int FRAC_BITS = 16,
   parameter int MAX_BLOCK = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  slp_pkg::slp_head_type               head,
   output logic                                take,
   input  slp_pkg::slp_cfg_type                cfg,
   input  logic                                pop,
   output logic                                empty,
   output logic signed [slp_pkg::SAMPLE_W-1:0] left_out,
   output logic signed [slp_pkg::SAMPLE_W-1:0] right_out,
   output logic                                playing
);
   import slp_pkg::*;

   localparam int DEPTH      = 2 ** ADDR_BITS;
   localparam int POS_W      = ADDR_BITS + FRAC_BITS + 1;
   localparam int IDX_W      = ADDR_BITS + 1;
   localparam int CMP_W      = (ADDR_BITS > LEN_W) ? ADDR_BITS + 2 : LEN_W + 2;
   localparam int LIM_W      = ((POS_W > FRAC_BITS + LEN_W) ? POS_W : FRAC_BITS + LEN_W) + 1;
   localparam int UP_SHIFT   = (FRAC_BITS >= STEP_FRAC) ? FRAC_BITS - STEP_FRAC : 0;
   localparam int DOWN_SHIFT = (FRAC_BITS < STEP_FRAC) ? STEP_FRAC - FRAC_BITS : 0;
   localparam int CNT_W      = $clog2(MAX_BLOCK + 1);
   localparam int BCMP_W     = (CNT_W > BLK_W) ? CNT_W : BLK_W;
   localparam int WORD_W     = 2 * SAMPLE_W;
   localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   slp_state_type              state_ff, state_in;
   logic signed [POS_W-1:0]    pos_ff, pos_in;
   logic signed [POS_W-1:0]    np_ff, np_in;
   logic                       playing_ff, playing_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [ADDR_BITS-1:0]       idx_ff, idx_in;
   logic [FRAC_BITS-1:0]       frac_ff, frac_in;
   logic                       va_ff, va_in;
   logic                       vb_ff, vb_in;
   logic [WORD_W-1:0]          sample_mem [DEPTH];
   logic [WORD_W-1:0]          rd_data_ff;
   logic [ADDR_BITS-1:0]       rd_addr;
   logic [ADDR_BITS-1:0]       wr_addr;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] res_left_ff, res_left_in;
   logic signed [SAMPLE_W-1:0] res_right_ff, res_right_in;
   logic                       res_play_ff, res_play_in;

   // Sequencer outputs.
   logic             mem_we;
   logic             rd_next;
   logic             frame_begin;
   logic             res_we;
   logic             res_zero;
   logic             start_we;
   logic             commit;
   slp_lane_ctl_type lane_ctl;

   logic                       slot_free;
   logic                       is_frame;
   logic signed [IDX_W-1:0]    idx_now;
   logic signed [CMP_W-1:0]    ia, ib, len_s, depth_s;
   logic [POS_W:0]             inc;
   logic signed [POS_W:0]      pos_x, np_raw;
   logic signed [POS_W-1:0]    np_sat;
   logic signed [LIM_W-1:0]    np_x, lim;
   logic                       at_end;
   logic [BCMP_W-1:0]          blk_raw, blk_c;
   logic [CNT_W-1:0]           count_inc;
   logic                       reached;
   logic signed [SAMPLE_W-1:0] lane_left, lane_right;

   assign slot_free = !rsp_valid_ff || pop;
   assign is_frame  = head.valid && (head.cmd.op == OP_FRAME) && playing_ff;
   assign wr_addr   = ADDR_BITS'(head.cmd.addr);

   // Read index and fraction of the current position, plus range checks.
   always_comb begin
      idx_now = IDX_W'(pos_ff >>> FRAC_BITS);
      ia      = CMP_W'(idx_now);
      ib      = ia + CMP_W'(1);
      len_s   = $signed(CMP_W'(cfg.length));
      depth_s = $signed(CMP_W'(DEPTH));
      rd_addr = rd_next ? idx_ff + ADDR_BITS'(1) : idx_now[ADDR_BITS-1:0];
   end

   // Next position, saturated to the signed range.
   always_comb begin
      inc    = ((POS_W + 1)'(cfg.step) << UP_SHIFT) >> DOWN_SHIFT;
      pos_x  = (POS_W + 1)'(pos_ff);
      np_raw = cfg.reverse ? pos_x - $signed(inc) : pos_x + $signed(inc);
      if (np_raw[POS_W] != np_raw[POS_W-1]) begin
         np_sat = np_raw[POS_W] ? POS_MIN : POS_MAX;
      end else begin
         np_sat = np_raw[POS_W-1:0];
      end
   end

   // Block counting and the end-of-buffer check on the updated position.
   always_comb begin
      np_x      = LIM_W'(np_ff);
      lim       = $signed(LIM_W'({cfg.length, {FRAC_BITS{1'b0}}}));
      at_end    = np_ff[POS_W-1] || (np_x >= lim);
      blk_raw   = BCMP_W'(cfg.block_frames);
      if (blk_raw == '0) begin
         blk_c = BCMP_W'(1);
      end else if (blk_raw > BCMP_W'(MAX_BLOCK)) begin
         blk_c = BCMP_W'(MAX_BLOCK);
      end else begin
         blk_c = blk_raw;
      end
      count_inc = count_ff + CNT_W'(1);
      reached   = (BCMP_W'(count_inc) >= blk_c);
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (is_frame) begin
               state_in = cfg.bypass ? ST_DONE : ST_RD1;
            end
         end
         ST_RD1:  state_in = ST_MULD;
         ST_MULD: state_in = ST_SUM;
         ST_SUM:  state_in = ST_MULV;
         ST_MULV: state_in = ST_ACC;
         ST_ACC:  state_in = ST_DONE;
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      take        = 1'b0;
      mem_we      = 1'b0;
      rd_next     = 1'b0;
      frame_begin = 1'b0;
      res_we      = 1'b0;
      res_zero    = 1'b0;
      start_we    = 1'b0;
      commit      = 1'b0;
      lane_ctl    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (is_frame) begin
               take        = 1'b1;
               frame_begin = 1'b1;
            end else if (head.valid && slot_free) begin
               // Loads, starts, unknown codes and frames while stopped finish at once.
               take     = 1'b1;
               res_we   = 1'b1;
               res_zero = 1'b1;
               mem_we   = (head.cmd.op == OP_LOAD);
               start_we = (head.cmd.op == OP_START) && (cfg.length != '0);
            end
         end
         ST_RD1: begin
            rd_next        = 1'b1;
            lane_ctl.cap_a = 1'b1;
         end
         ST_MULD: lane_ctl.mul_d = 1'b1;
         ST_SUM:  lane_ctl.sum   = 1'b1;
         ST_MULV: lane_ctl.mul_v = 1'b1;
         ST_ACC:  lane_ctl.acc   = 1'b1;
         ST_DONE: begin
            if (slot_free) begin
               res_we   = 1'b1;
               commit   = 1'b1;
               res_zero = cfg.bypass;
            end
         end
         default: begin
            take = 1'b0;
         end
      endcase
   end

   // Playback state and per-frame operand registers.
   always_comb begin
      pos_in     = pos_ff;
      playing_in = playing_ff;
      count_in   = count_ff;
      np_in      = np_ff;
      idx_in     = idx_ff;
      frac_in    = frac_ff;
      va_in      = va_ff;
      vb_in      = vb_ff;
      if (start_we) begin
         pos_in     = POS_W'({wr_addr, {FRAC_BITS{1'b0}}});
         playing_in = 1'b1;
         count_in   = '0;
      end
      if (commit) begin
         pos_in = np_ff;
         if (reached) begin
            count_in = '0;
            if (at_end) begin
               playing_in = 1'b0;
            end
         end else begin
            count_in = count_inc;
         end
      end
      if (frame_begin) begin
         np_in   = np_sat;
         idx_in  = idx_now[ADDR_BITS-1:0];
         frac_in = pos_ff[FRAC_BITS-1:0];
         va_in   = !ia[CMP_W-1] && (ia < len_s) && (ia < depth_s);
         vb_in   = !ib[CMP_W-1] && (ib < len_s) && (ib < depth_s);
      end
   end

   // Result register: one finished result waits here for the consumer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !pop;
      res_left_in  = res_left_ff;
      res_right_in = res_right_ff;
      res_play_in  = res_play_ff;
      if (res_we) begin
         rsp_valid_in = 1'b1;
         res_left_in  = res_zero ? '0 : lane_left;
         res_right_in = res_zero ? '0 : lane_right;
         res_play_in  = playing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         playing_ff   <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         playing_ff   <= playing_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      np_ff        <= np_in;
      idx_ff       <= idx_in;
      frac_ff      <= frac_in;
      va_ff        <= va_in;
      vb_ff        <= vb_in;
      res_left_ff  <= res_left_in;
      res_right_ff <= res_right_in;
      res_play_ff  <= res_play_in;
   end

   // Sample store: left in the upper half of each word, right in the lower.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sample_mem[wr_addr] <= {head.cmd.left, head.cmd.right};
      end
      rd_data_ff <= sample_mem[rd_addr];
   end

   slp_lane #(
      .FRAC_BITS (FRAC_BITS)
   ) u_lane_left (
      .clock      (clock),
      .ctl        (lane_ctl),
      .rd_sample  (rd_data_ff[WORD_W-1:SAMPLE_W]),
      .va         (va_ff),
      .vb         (vb_ff),
      .frac       (frac_ff),
      .volume     (cfg.volume),
      .sample_out (lane_left)
   );

   slp_lane #(
      .FRAC_BITS (FRAC_BITS)
   ) u_lane_right (
      .clock      (clock),
      .ctl        (lane_ctl),
      .rd_sample  (rd_data_ff[SAMPLE_W-1:0]),
      .va         (va_ff),
      .vb         (vb_ff),
      .frac       (frac_ff),
      .volume     (cfg.volume),
      .sample_out (lane_right)
   );

   assign empty     = !rsp_valid_ff;
   assign left_out  = res_left_ff;
   assign right_out = res_right_ff;
   assign playing   = res_play_ff;

   // Playback can only be switched on by a start transaction.
   assert property (@(posedge clock) disable iff (reset) $rose(playing_ff) |-> $past(start_we))
      else $error("slp_back: playback enabled without a start");

   // The position moves only on a start or when a frame is committed.
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(start_we) && !$past(commit)) |-> $stable(pos_ff))
      else $error("slp_back: position changed outside start or frame commit");

   // A frame's result is committed only once the result register has room.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !pop) |=> (state_ff == ST_DONE && rsp_valid_ff))
      else $error("slp_back: frame left its final step with the result register full");

   // The frame counter wraps before it reaches the largest block size.
   assert property (@(posedge clock) disable iff (reset)
      BCMP_W'(count_ff) < BCMP_W'(MAX_BLOCK))
      else $error("slp_back: frame counter out of range");

endmodule

`default_nettype wire

FILE: sim/tb.sv
`default_nettype none

module tb;
   import slp_pkg::*;

   localparam int ITEM_TARGET   = 1900;
   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 16;
   localparam int FRAC          = 16;
   localparam int ONE_POS       = 65536;
   localparam int BLOCK_CAP     = 4096;
   localparam int PLAN          = 0;
   localparam int LIVE          = 1;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam longint POS_MAX   = 64'sd4294967295;
   localparam longint POS_MIN   = -64'sd4294967296;

   typedef struct packed {
      logic [FUNC_W-1:0]          func;
      logic [ADDR_IN_W-1:0]       addr;
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
   } player_cmd_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic                       playing;
   } player_frame_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       push;
   logic                       full;
   logic [FUNC_W-1:0]          req_func;
   logic [ADDR_IN_W-1:0]       req_addr;
   logic signed [SAMPLE_W-1:0] req_left_in;
   logic signed [SAMPLE_W-1:0] req_right_in;
   logic                       empty;
   logic                       pop;
   logic signed [SAMPLE_W-1:0] rsp_left_out;
   logic signed [SAMPLE_W-1:0] rsp_right_out;
   logic                       rsp_playing;
   logic                       psel;
   logic                       penable;
   logic                       pwrite;
   logic [CSR_ADDR_W-1:0]      paddr;
   logic [CSR_DATA_W-1:0]      pwdata;
   logic [CSR_DATA_W-1:0]      prdata;
   logic                       pready;

   // Player state, held twice: one copy runs ahead while the stimulus is built,
   // the other follows the transactions that the block accepts.
   shortint sample_mem [2][2][65536];
   bit      plan_loaded [65536];
   longint  play_pos [2];
   bit      play_on [2];
   int      block_count [2];

   // Register settings, only changed while the block is idle.
   logic [STEP_W-1:0] cfg_step;
   logic [VOL_W-1:0]  cfg_volume;
   logic              cfg_reverse;
   logic              cfg_bypass;
   logic [LEN_W-1:0]  cfg_length;
   logic [BLK_W-1:0]  cfg_block;

   player_cmd_type   cmd_backlog [$];
   player_frame_type frames_due [$];
   int               n_queued;
   int               n_accepted;
   int               quiet_cycles;
   int               send_gap;
   int               drain_gap;
   bit               calm;
   bit               req_fired;
   bit               failed;

   stereo_linear_interp_sample_player u_top (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_func      (req_func),
      .req_addr      (req_addr),
      .req_left_in   (req_left_in),
      .req_right_in  (req_right_in),
      .empty         (empty),
      .pop           (pop),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .rsp_playing   (rsp_playing),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   always #2 clock = ~clock;

   // An entry outside the loaded length, or below zero, reads as silence.
   function automatic longint entry_at(input int c, input int ch, input longint i);
      longint len_l;
      len_l = cfg_length;
      if (i < 0 || i >= len_l) return 0;
      return sample_mem[c][ch][i];
   endfunction

   // Linear interpolation between two neighbouring entries, then the gain,
   // truncated toward zero and clipped to 16 bits.
   function automatic logic signed [SAMPLE_W-1:0] mix_channel(input int c, input int ch,
                                                              input longint idx,
                                                              input longint frac);
      longint a, b, gain, v;
      a = entry_at(c, ch, idx);
      b = entry_at(c, ch, idx + 1);
      gain = cfg_volume;
      v = (a * ONE_POS + (b - a) * frac) * gain;
      v = v / (longint'(1) << (FRAC + VOL_FRAC));
      if (v > 32767) v = 32767;
      else if (v < -32768) v = -32768;
      return v[SAMPLE_W-1:0];
   endfunction

   // Applies one transaction to copy c of the player and returns its frame.
   function automatic player_frame_type player_step(input int c, input player_cmd_type cmd);
      player_frame_type res;
      longint idx, frac, inc, nxt, base;
      int blk;
      res = '0;
      case (cmd.func)
         FUNC_LOAD: begin
            sample_mem[c][0][cmd.addr] = cmd.left;
            sample_mem[c][1][cmd.addr] = cmd.right;
            if (c == PLAN) plan_loaded[cmd.addr] = 1'b1;
         end
         FUNC_START: begin
            // A start is refused while the length register is zero.
            if (cfg_length != 0) begin
               base = cmd.addr;
               play_pos[c] = base * ONE_POS;
               play_on[c] = 1'b1;
               block_count[c] = 0;
            end
         end
         FUNC_FRAME: begin
            if (play_on[c]) begin
               idx = play_pos[c] >>> FRAC;
               frac = play_pos[c] - idx * ONE_POS;
               if (!cfg_bypass) begin
                  res.left = mix_channel(c, 0, idx, frac);
                  res.right = mix_channel(c, 1, idx, frac);
               end
               inc = cfg_step;
               nxt = cfg_reverse ? play_pos[c] - inc : play_pos[c] + inc;
               if (nxt > POS_MAX) nxt = POS_MAX;
               if (nxt < POS_MIN) nxt = POS_MIN;
               play_pos[c] = nxt;
               // End of buffer is only checked once per block of frames.
               blk = cfg_block;
               if (blk == 0) blk = 1;
               if (blk > BLOCK_CAP) blk = BLOCK_CAP;
               block_count[c]++;
               if (block_count[c] >= blk) begin
                  block_count[c] = 0;
                  base = cfg_length;
                  if (play_pos[c] >= base * ONE_POS || play_pos[c] < 0) play_on[c] = 1'b0;
               end
            end
         end
         default: ;
      endcase
      res.playing = play_on[c];
      return res;
   endfunction

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Mostly short gaps, now and then a long one, none at all in calm stretches.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Adds a transaction to the backlog. Before a frame, any entry that the frame
   // will read and that was never loaded is loaded first with random content.
   task automatic queue_cmd(input logic [FUNC_W-1:0] func, input logic [15:0] addr,
                            input logic [15:0] l, input logic [15:0] r);
      player_cmd_type cmd, fill;
      longint idx, i, len_l;
      len_l = cfg_length;
      if (func == FUNC_FRAME && play_on[PLAN] && !cfg_bypass) begin
         idx = play_pos[PLAN] >>> FRAC;
         for (i = idx; i <= idx + 1; i++) begin
            if (i >= 0 && i < len_l && !plan_loaded[i]) begin
               fill = '{FUNC_LOAD, i[15:0], rand_sample(), rand_sample()};
               cmd_backlog.push_back(fill);
               void'(player_step(PLAN, fill));
               n_queued++;
            end
         end
      end
      cmd = '{func, addr, l, r};
      cmd_backlog.push_back(cmd);
      void'(player_step(PLAN, cmd));
      n_queued++;
   endtask

   task automatic write_reg(input slp_reg_type r, input logic [31:0] v);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {r, 2'b00};
      pwdata <= v;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (r)
         REG_STEP:    cfg_step = v[STEP_W-1:0];
         REG_VOLUME:  cfg_volume = v[VOL_W-1:0];
         REG_REVERSE: cfg_reverse = v[0];
         REG_BYPASS:  cfg_bypass = v[0];
         REG_LENGTH:  cfg_length = v[LEN_W-1:0];
         REG_BLOCK:   cfg_block = v[BLK_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic write_config(input logic [STEP_W-1:0] s, input logic [VOL_W-1:0] v,
                               input logic rv, input logic bp,
                               input logic [LEN_W-1:0] len, input logic [BLK_W-1:0] blk);
      write_reg(REG_STEP, 32'(s));
      write_reg(REG_VOLUME, 32'(v));
      write_reg(REG_REVERSE, 32'(rv));
      write_reg(REG_BYPASS, 32'(bp));
      write_reg(REG_LENGTH, 32'(len));
      write_reg(REG_BLOCK, 32'(blk));
   endtask

   task automatic random_config();
      logic [STEP_W-1:0] s;
      logic [VOL_W-1:0]  v;
      logic [LEN_W-1:0]  len;
      logic [BLK_W-1:0]  blk;
      case ($urandom_range(0, 7))
         0: s = '0;
         1: s = '1;
         2: s = 24'h010000;
         3, 4, 5: s = 24'($urandom_range(1, 24'h03FFFF));
         default: s = 24'($urandom_range(0, 24'hFFFFFF));
      endcase
      case ($urandom_range(0, 4))
         0: v = '0;
         1: v = '1;
         2: v = VOL_RESET;
         default: v = 16'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 11))
         0: len = '0;
         1, 2: len = '1;
         3, 4, 5, 6: len = 16'($urandom_range(1, 64));
         default: len = 16'($urandom_range(1, 65535));
      endcase
      case ($urandom_range(0, 7))
         0: blk = '0;
         1: blk = '1;
         2: blk = 13'd4096;
         3, 4, 5: blk = 13'($urandom_range(1, 16));
         default: blk = 13'($urandom_range(1, 8191));
      endcase
      write_config(s, v, 1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0, len, blk);
   endtask

   // Mostly a start inside the loaded range followed by a run of frames; the
   // rest is stray loads, starts, frames and unknown codes.
   task automatic play_phase(input int n);
      int stop_at, frames, k;
      logic [15:0] start;
      stop_at = n_queued + n;
      while (n_queued < stop_at) begin
         case ($urandom_range(0, 9))
            0: queue_cmd(FUNC_LOAD, 16'($urandom_range(0, 65535)), rand_sample(),
                         rand_sample());
            1: queue_cmd(FUNC_UNUSED, 16'($urandom_range(0, 65535)), rand_sample(),
                         rand_sample());
            2: queue_cmd(FUNC_START, 16'($urandom_range(0, 65535)), rand_sample(),
                         rand_sample());
            3: queue_cmd(FUNC_FRAME, 16'($urandom_range(0, 65535)), rand_sample(),
                         rand_sample());
            default: begin
               if (cfg_length == 0) start = 16'($urandom_range(0, 65535));
               else start = 16'($urandom_range(0, cfg_length - 1));
               queue_cmd(FUNC_START, start, rand_sample(), rand_sample());
               frames = ($urandom_range(0, 19) == 0) ? 300 : $urandom_range(1, 40);
               for (k = 0; k < frames; k++) begin
                  if ($urandom_range(0, 15) == 0)
                     queue_cmd(FUNC_LOAD, start + 16'($urandom_range(0, 8)), rand_sample(),
                               rand_sample());
                  queue_cmd(FUNC_FRAME, 16'($urandom_range(0, 65535)), rand_sample(),
                            rand_sample());
               end
            end
         endcase
      end
   endtask

   // Waits until every transaction is in and every frame is out, then lets the
   // pipeline run dry.
   task automatic settle();
      while (n_accepted != n_queued || frames_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Input side: a new transaction is offered once the previous one was taken.
   always @(negedge clock) begin : drive
      player_cmd_type cmd;
      if ($urandom_range(0, 199) == 0) calm = !calm;
      if (reset) begin
         push <= 1'b0;
         pop <= 1'b0;
      end else begin
         if (!push || req_fired) begin
            if (send_gap > 0) begin
               push <= 1'b0;
               send_gap--;
            end else if (cmd_backlog.size() != 0) begin
               cmd = cmd_backlog.pop_front();
               req_func <= cmd.func;
               req_addr <= cmd.addr;
               req_left_in <= cmd.left;
               req_right_in <= cmd.right;
               push <= 1'b1;
               send_gap = idle_len();
            end else begin
               push <= 1'b0;
            end
         end
         // Result side: stall the reader now and then.
         if (drain_gap > 0) begin
            pop <= 1'b0;
            drain_gap--;
         end else begin
            pop <= 1'b1;
            if ($urandom_range(0, 3) == 0) drain_gap = idle_len();
         end
      end
   end

   // Accepted transactions feed the predictor; accepted results are checked.
   always @(posedge clock) begin : monitor
      player_cmd_type   cmd;
      player_frame_type got;
      player_frame_type want;
      bit               moved;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         moved = 1'b0;
         req_fired <= push && !full;
         if (push && !full) begin
            cmd = '{req_func, req_addr, req_left_in, req_right_in};
            frames_due.push_back(player_step(LIVE, cmd));
            n_accepted++;
            moved = 1'b1;
         end
         if (pop && !empty) begin
            moved = 1'b1;
            got = '{rsp_left_out, rsp_right_out, rsp_playing};
            if (frames_due.size() == 0) begin
               $error("result with no transaction outstanding: left %0d right %0d playing %0d",
                      got.left, got.right, got.playing);
               failed = 1'b1;
            end else begin
               want = frames_due.pop_front();
               if (got.left !== want.left) begin
                  $error("rsp_left_out: expected %0d, got %0d", want.left, got.left);
                  failed = 1'b1;
               end
               if (got.right !== want.right) begin
                  $error("rsp_right_out: expected %0d, got %0d", want.right, got.right);
                  failed = 1'b1;
               end
               if (got.playing !== want.playing) begin
                  $error("rsp_playing: expected %0d, got %0d", want.playing, got.playing);
                  failed = 1'b1;
               end
            end
         end
         // Watchdog on cycles in which nothing moves.
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: errors");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      push = 1'b0;
      pop = 1'b0;
      req_func = FUNC_LOAD;
      req_addr = '0;
      req_left_in = '0;
      req_right_in = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      cfg_step = STEP_RESET;
      cfg_volume = VOL_RESET;
      cfg_reverse = 1'b0;
      cfg_bypass = 1'b0;
      cfg_length = '0;
      cfg_block = BLK_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Settings after reset, nothing loaded: a frame while stopped, a refused
      // start, an unknown code and loads with extreme values.
      queue_cmd(FUNC_FRAME, 16'h0000, 16'h0000, 16'h0000);
      queue_cmd(FUNC_START, 16'h0000, 16'h0000, 16'h0000);
      queue_cmd(FUNC_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_cmd(FUNC_LOAD, 16'h0000, 16'h7FFF, 16'h8000);
      queue_cmd(FUNC_LOAD, 16'h0001, 16'h8000, 16'h7FFF);
      queue_cmd(FUNC_LOAD, 16'hFFFF, 16'h8000, 16'h7FFF);
      settle();

      // Half-speed playback at the largest gain: interpolation, clipping, reads past the
      // length and a stop at the end; then a start beyond the loaded range.
      write_config(24'h008000, 16'hFFFF, 1'b0, 1'b0, 16'd2, 13'd1);
      queue_cmd(FUNC_START, 16'h0000, 16'h0000, 16'h0000);
      repeat (5) queue_cmd(FUNC_FRAME, 16'h0000, 16'h0000, 16'h0000);
      queue_cmd(FUNC_START, 16'hFFFF, 16'h0000, 16'h0000);
      repeat (2) queue_cmd(FUNC_FRAME, 16'h0000, 16'h0000, 16'h0000);
      settle();

      // Bypass in reverse at the largest step, with a zero block size.
      write_config('1, 16'h0000, 1'b1, 1'b1, '1, 13'd0);
      queue_cmd(FUNC_START, 16'hFFFE, 16'h0000, 16'h0000);
      repeat (3) queue_cmd(FUNC_FRAME, 16'h0000, 16'h0000, 16'h0000);
      settle();

      // Forward from the last entry: the position saturates at its upper limit.
      write_config('1, VOL_RESET, 1'b0, 1'b0, '1, '1);
      queue_cmd(FUNC_START, 16'hFFFF, 16'h0000, 16'h0000);
      repeat (2) queue_cmd(FUNC_FRAME, 16'h0000, 16'h0000, 16'h0000);
      settle();

      while (n_queued < ITEM_TARGET) begin
         random_config();
         play_phase($urandom_range(30, 90));
         settle();
      end

      if (!failed) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

endmodule

`default_nettype wire
